// ===== src/bgps_pkg.sv =====
// Package for the beat grid peak snapper: field widths, codes and reset values.
package bgps_pkg;

   // Widths of the channel fields.
   localparam int LEVEL_W    = 16;
   localparam int FRAME_W    = 16;
   localparam int INTERVAL_W = 24;
   localparam int CSR_DATA_W = 24;
   localparam int CSR_INDEX_W = 2;

   // Kind of an emitted beat.
   typedef enum logic [1:0] {
      KIND_ANCHOR = 2'd0,
      KIND_PEAK   = 2'd1,
      KIND_CENTER = 2'd2
   } beat_kind_type;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BEAT_INTERVAL    = 2'd0,
      CSR_ACTIVATION_FLOOR = 2'd1,
      CSR_START_FRAME      = 2'd2,
      CSR_END_FRAME        = 2'd3
   } csr_index_type;

   // Register values after reset.
   localparam logic [INTERVAL_W-1:0]    BEAT_INTERVAL_RESET    = 24'd5120;
   localparam logic signed [LEVEL_W-1:0] ACTIVATION_FLOOR_RESET = 16'sd0;
   localparam logic [FRAME_W-1:0]       START_FRAME_RESET      = 16'd0;
   localparam logic [FRAME_W-1:0]       END_FRAME_RESET        = 16'hFFFF;

   // Running maximum starts at -1.0 in Q1.15.
   localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = 16'sh8000;

endpackage

// ===== src/bgps_if.sv =====
// Channel interfaces of the beat grid peak snapper: samples, beats and register writes.

interface bgps_req_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [bgps_pkg::LEVEL_W-1:0]       activation_level;
   logic                                      last_sample;

   modport source (output valid, output activation_level, output last_sample, input ready);
   modport sink   (input valid, input activation_level, input last_sample, output ready);
endinterface

interface bgps_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [bgps_pkg::FRAME_W-1:0]     beat_frame;
   logic [1:0]                       beat_kind;

   modport source (output valid, output beat_frame, output beat_kind, input ready);
   modport sink   (input valid, input beat_frame, input beat_kind, output ready);
endinterface

interface bgps_csr_if;
   logic                                valid;
   logic                                ready;
   logic [bgps_pkg::CSR_INDEX_W-1:0]    index;
   logic [bgps_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/beat_grid_peak_snapper.sv =====
// Beat grid peak snapper: snaps a fixed-interval beat grid to activation peaks.
//
// One activation sample is taken per clock cycle, and the beat it causes, if any, is
// presented in the result register on the following cycle. Sample intake stalls only
// while that result register holds a beat the sink has not yet taken. The clock rate is
// set by the single update path that advances the grid cursor by one interval, rounds the
// new cursor to a centre frame and compares it against the end frame. The first sample
// after reset (and after every sample marked last) is frame 0; frame start_frame is
// emitted as the anchor beat, and each later grid window yields at most one beat: its first
// strict maximum or its rounded centre. Register writes are always taken at once and apply
// from the next sample.
module beat_grid_peak_snapper #(
   parameter int MAX_FRAMES = 65536,
   parameter int FRAC_BITS  = 8
) (
   input  logic          clock,
   input  logic          reset,
   bgps_req_if.sink      req_chan,
   bgps_rsp_if.source    rsp_chan,
   bgps_csr_if.sink      csr_chan
);

   // Widths of the frame, cursor and comparison domains.
   localparam int FW_RAW = $clog2(MAX_FRAMES) + 1;
   localparam int CW     = (FW_RAW > 17) ? FW_RAW : 17;
   localparam int CUR_W  = ((16 + FRAC_BITS > 24) ? 16 + FRAC_BITS : 24) + 1;
   localparam int CEN_W  = CUR_W + 1 - FRAC_BITS;
   localparam int AW     = (CW > CEN_W) ? CW : CEN_W;
   localparam int HW_W   = 25 - FRAC_BITS - 2;
   localparam int WB     = (CUR_W > CW + FRAC_BITS) ? CUR_W : CW + FRAC_BITS;
   localparam int DW     = (CW + FRAC_BITS + 1 > 24) ? CW + FRAC_BITS + 1 : 24;

   localparam logic [AW-1:0]    LAST_IDX    = AW'(MAX_FRAMES - 1);
   localparam logic [CW-1:0]    LAST_FRAME  = CW'(MAX_FRAMES - 1);
   localparam logic [CW-1:0]    FRAME_LIMIT = CW'(MAX_FRAMES);
   localparam logic [23:0]      IV_MIN      = 24'(4 << FRAC_BITS);
   localparam logic [CUR_W:0]   ROUND_HALF  = (CUR_W + 1)'(1) << (FRAC_BITS - 1);
   localparam logic [24:0]      HW_ROUND    = 25'(1) << (FRAC_BITS + 1);

   // Rounds a cursor to its nearest frame, halves rounding up.
   function automatic logic [CEN_W-1:0] center_of(input logic [CUR_W-1:0] cur);
      logic [CUR_W:0] sum;
      sum = {1'b0, cur} + ROUND_HALF;
      return sum[CUR_W:FRAC_BITS];
   endfunction

   // Configuration registers.
   logic [23:0]        interval_ff;
   logic signed [15:0] floor_ff;
   logic [15:0]        start_ff;
   logic [15:0]        end_ff;

   // Run state.
   logic [CW-1:0]      frame_ff, frame_in;
   logic [CUR_W-1:0]   cursor_ff, cursor_in;
   logic               window_open_ff, window_open_in;
   logic signed [15:0] best_level_ff, best_level_in;
   logic [CW-1:0]      best_frame_ff, best_frame_in;
   logic [CW-1:0]      last_beat_ff, last_beat_in;
   logic               anchor_seen_ff, anchor_seen_in;

   // Result register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [15:0]               beat_frame_ff, beat_frame_in;
   bgps_pkg::beat_kind_type   beat_kind_ff, beat_kind_in;

   // Per-sample decision signals.
   logic                req_accept;
   logic [23:0]         iv;
   logic [24:0]         hw_sum;
   logic [HW_W-1:0]     hw_raw;
   logic [AW-1:0]       hw;
   logic [AW-1:0]       idx;
   logic [AW-1:0]       cur_center;
   logic [AW-1:0]       win_lo;
   logic [AW-1:0]       win_hi_raw;
   logic [AW-1:0]       win_hi;
   logic                in_range;
   logic                take_anchor;
   logic                win_step;
   logic                best_update;
   logic signed [15:0]  best_level_upd;
   logic [CW-1:0]       best_frame_upd;
   logic                win_done;
   logic [CW-1:0]       fin_frame;
   logic                tail_done;
   logic                finish;
   logic                below_floor;
   logic                too_close;
   logic [AW-1:0]       chosen;
   logic                fin_emit;
   logic [CUR_W-1:0]    cursor_base;
   logic [CUR_W-1:0]    next_cursor;
   logic [AW-1:0]       next_center;
   logic                load_cursor;
   logic                grid_end;

   assign req_accept     = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.beat_frame = beat_frame_ff;
   assign rsp_chan.beat_kind  = beat_kind_ff;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= bgps_pkg::BEAT_INTERVAL_RESET;
         floor_ff    <= bgps_pkg::ACTIVATION_FLOOR_RESET;
         start_ff    <= bgps_pkg::START_FRAME_RESET;
         end_ff      <= bgps_pkg::END_FRAME_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            bgps_pkg::CSR_BEAT_INTERVAL:    interval_ff <= csr_chan.data;
            bgps_pkg::CSR_ACTIVATION_FLOOR: floor_ff    <= csr_chan.data[15:0];
            bgps_pkg::CSR_START_FRAME:      start_ff    <= csr_chan.data[15:0];
            bgps_pkg::CSR_END_FRAME:        end_ff      <= csr_chan.data[15:0];
            default: ;
         endcase
      end
   end

   // Window geometry around the current cursor.
   always_comb begin
      iv         = (interval_ff < IV_MIN) ? IV_MIN : interval_ff;
      hw_sum     = {1'b0, iv} + HW_ROUND;
      hw_raw     = hw_sum[24:FRAC_BITS+2];
      hw         = (hw_raw == '0) ? AW'(1) : AW'(hw_raw);
      idx        = AW'(frame_ff);
      cur_center = AW'(center_of(cursor_ff));
      win_lo     = (cur_center > hw) ? cur_center - hw : '0;
      win_hi_raw = cur_center + hw;
      win_hi     = (win_hi_raw > LAST_IDX) ? LAST_IDX : win_hi_raw;
   end

   // Anchor detection, running maximum and window close.
   always_comb begin
      in_range       = frame_ff < FRAME_LIMIT;
      take_anchor    = in_range && !anchor_seen_ff && (frame_ff == CW'(start_ff));
      win_step       = in_range && !take_anchor && window_open_ff;
      best_update    = win_step && (idx >= win_lo) && (idx <= win_hi)
                       && (req_chan.activation_level > best_level_ff);
      best_level_upd = best_update ? req_chan.activation_level : best_level_ff;
      best_frame_upd = best_update ? frame_ff : best_frame_ff;
      win_done       = win_step && (idx >= win_hi);
      // A run that ends inside a window decides it if the cursor has been reached.
      fin_frame      = in_range ? frame_ff : LAST_FRAME;
      tail_done      = req_chan.last_sample && window_open_ff && !win_done && !take_anchor
                       && (WB'(cursor_ff) <= (WB'(fin_frame) << FRAC_BITS));
      finish         = win_done || tail_done;
   end

   // Peak or centre choice for a closing window.
   always_comb begin
      below_floor = best_level_upd < floor_ff;
      too_close   = (best_frame_upd > last_beat_ff)
                    && ((DW'(best_frame_upd - last_beat_ff) << (FRAC_BITS + 1)) < DW'(iv));
      chosen      = (below_floor || too_close) ? cur_center : AW'(best_frame_upd);
      fin_emit    = finish && (chosen > AW'(last_beat_ff));
   end

   // Cursor advance, shared by the anchor and by every closing window.
   always_comb begin
      cursor_base = take_anchor ? (CUR_W'(start_ff) << FRAC_BITS) : cursor_ff;
      next_cursor = cursor_base + CUR_W'(iv);
      next_center = AW'(center_of(next_cursor));
      load_cursor = (take_anchor && (end_ff > start_ff)) || finish;
      grid_end    = (next_cursor > (CUR_W'(end_ff) << FRAC_BITS)) || (next_center > LAST_IDX);
   end

   // Next run state.
   always_comb begin
      frame_in       = frame_ff;
      cursor_in      = cursor_ff;
      window_open_in = window_open_ff;
      best_level_in  = best_level_upd;
      best_frame_in  = best_frame_upd;
      last_beat_in   = last_beat_ff;
      anchor_seen_in = anchor_seen_ff;

      if (in_range) begin
         frame_in = frame_ff + CW'(1);
      end
      if (take_anchor) begin
         anchor_seen_in = 1'b1;
         last_beat_in   = CW'(start_ff);
         window_open_in = 1'b0;
      end
      if (fin_emit) begin
         last_beat_in = chosen[CW-1:0];
      end
      if (load_cursor) begin
         cursor_in = next_cursor;
         if (grid_end) begin
            window_open_in = 1'b0;
         end else begin
            window_open_in = 1'b1;
            best_level_in  = bgps_pkg::LEVEL_MIN;
            best_frame_in  = next_center[CW-1:0];
         end
      end
      // The final sample of a run returns the run state to its reset values.
      if (req_chan.last_sample) begin
         frame_in       = '0;
         cursor_in      = '0;
         window_open_in = 1'b0;
         best_level_in  = bgps_pkg::LEVEL_MIN;
         best_frame_in  = '0;
         last_beat_in   = '0;
         anchor_seen_in = 1'b0;
      end
   end

   // Result register loading and draining.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      beat_frame_in = beat_frame_ff;
      beat_kind_in  = beat_kind_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_accept) begin
         if (take_anchor) begin
            rsp_valid_in  = 1'b1;
            beat_frame_in = start_ff;
            beat_kind_in  = bgps_pkg::KIND_ANCHOR;
         end else if (fin_emit) begin
            rsp_valid_in  = 1'b1;
            beat_frame_in = chosen[15:0];
            beat_kind_in  = (below_floor || too_close) ? bgps_pkg::KIND_CENTER
                                                       : bgps_pkg::KIND_PEAK;
         end
      end
   end

   // Control and run state.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         frame_ff       <= '0;
         cursor_ff      <= '0;
         window_open_ff <= 1'b0;
         best_level_ff  <= bgps_pkg::LEVEL_MIN;
         best_frame_ff  <= '0;
         last_beat_ff   <= '0;
         anchor_seen_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            frame_ff       <= frame_in;
            cursor_ff      <= cursor_in;
            window_open_ff <= window_open_in;
            best_level_ff  <= best_level_in;
            best_frame_ff  <= best_frame_in;
            last_beat_ff   <= last_beat_in;
            anchor_seen_ff <= anchor_seen_in;
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      beat_frame_ff <= beat_frame_in;
      beat_kind_ff  <= beat_kind_in;
   end

   // A grid window only exists once the anchor has been emitted.
   assert property (@(posedge clock) disable iff (reset)
      window_open_ff |-> anchor_seen_ff)
      else $error("grid window open before the anchor beat");

   // A beat waiting on the sink keeps its value until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready)
      |=> (rsp_valid_ff && $stable(beat_frame_ff) && $stable(beat_kind_ff)))
      else $error("waiting beat changed before it was taken");

   // A pending beat is never overwritten by a new sample.
   assert property (@(posedge clock) disable iff (reset)
      !(req_accept && rsp_valid_ff && !rsp_chan.ready))
      else $error("sample taken while the result register was blocked");

   // The final sample of a run clears the run state.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_chan.last_sample)
      |=> (!anchor_seen_ff && !window_open_ff && frame_ff == '0))
      else $error("run state not cleared after the final sample");

   // Within a run, an emitted window beat becomes the last beat.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && fin_emit && !take_anchor && !req_chan.last_sample)
      |=> (AW'(last_beat_ff) == $past(chosen)))
      else $error("last beat not updated by an emitted window beat");

endmodule

// ===== test/tb_beat_grid_peak_snapper.sv =====
// Self-checking testbench for the beat grid peak snapper: directed table and random runs.
`timescale 1ns / 1ps

module tb_beat_grid_peak_snapper;

   localparam int FRAC          = 8;
   localparam int FRAME_LIMIT   = 65536;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int DRAIN_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_CYCLES   = 400;
   localparam int NUM_PHASES    = 12;
   localparam int PHASE_ITEMS   = 140;

   // One expected or observed beat.
   typedef struct packed {
      logic [bgps_pkg::FRAME_W-1:0] frame;
      bgps_pkg::beat_kind_type      kind;
   } beat_type;

   // How a row is checked: by the predictor, expecting no beat, or against a value in the table.
   typedef enum logic [1:0] {
      EXP_MODEL,
      EXP_NONE,
      EXP_BEAT
   } check_type;

   typedef enum logic {
      ROW_SAMPLE,
      ROW_WRITE
   } row_op_type;

   typedef struct packed {
      row_op_type                   op;
      bgps_pkg::csr_index_type      reg_idx;
      logic [23:0]                  value;
      logic                         last;
      check_type                    check;
      logic [bgps_pkg::FRAME_W-1:0] frame;
      bgps_pkg::beat_kind_type      kind;
   } row_type;

   localparam beat_type NO_BEAT = '{16'h0000, bgps_pkg::KIND_ANCHOR};

   logic clock;
   logic reset;

   bgps_req_if req_bus ();
   bgps_rsp_if rsp_bus ();
   bgps_csr_if csr_bus ();

   beat_grid_peak_snapper DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Register shadow, kept in step with the configuration writes.
   logic [bgps_pkg::INTERVAL_W-1:0]  cfg_interval;
   logic signed [bgps_pkg::LEVEL_W-1:0] cfg_floor;
   logic [bgps_pkg::FRAME_W-1:0]     cfg_start;
   logic [bgps_pkg::FRAME_W-1:0]     cfg_end;

   // Predicted run state of the snapper.
   logic [16:0]                         frame_idx;
   logic [25:0]                         cursor;
   logic                                win_open;
   logic signed [bgps_pkg::LEVEL_W-1:0] peak_level;
   logic [bgps_pkg::FRAME_W-1:0]        peak_frame;
   logic [bgps_pkg::FRAME_W-1:0]        last_beat_frame;
   logic                                anchor_done;

   beat_type beats_due[$];

   // Side band that travels with each sample transaction.
   check_type row_check;
   beat_type  row_beat;

   int  send_idle_pct;
   int  recv_idle_pct;
   bit  stall_go;
   logic rsp_hold;

   int failures;
   int cycles;
   int n_samples;
   int n_runs;
   int n_writes;
   int n_settings;
   int kind_seen [0:2];

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Cycle counter that ends a run that hangs.
   initial begin : watchdog
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("beat_grid_peak_snapper regression: fail");
      $finish;
   end

   function automatic void note_failure(input string msg);
      if (failures < 10) begin
         $display("[%0t] ERROR: %s", $realtime, msg);
      end
      failures++;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------------------

   // Interval in Q16.8, never below four frames.
   function automatic logic [24:0] step_q();
      return (cfg_interval < 24'd1024) ? 25'd1024 : {1'b0, cfg_interval};
   endfunction

   // Cursor rounded to a frame, halves up.
   function automatic logic [17:0] centre_of(input logic [25:0] c);
      return 18'((c + 26'd128) >> FRAC);
   endfunction

   function automatic void run_clear();
      frame_idx       = '0;
      cursor          = '0;
      win_open        = 1'b0;
      peak_level      = bgps_pkg::LEVEL_MIN;
      peak_frame      = '0;
      last_beat_frame = '0;
      anchor_done     = 1'b0;
   endfunction

   // Place the cursor; a position past the end frame or the frame range ends the grid.
   function automatic void cursor_load(input logic [25:0] c);
      cursor = c;
      if (c > {2'b00, cfg_end, 8'h00} || centre_of(c) > FRAME_LIMIT - 1) begin
         win_open = 1'b0;
      end else begin
         win_open   = 1'b1;
         peak_level = bgps_pkg::LEVEL_MIN;
         peak_frame = 16'(centre_of(c));
      end
   endfunction

   // Decide the pending window, then step the cursor by one interval.
   function automatic logic window_close(output beat_type b);
      logic [24:0]                  iv;
      logic [bgps_pkg::FRAME_W-1:0] ctr;
      logic [bgps_pkg::FRAME_W-1:0] pick;
      bgps_pkg::beat_kind_type      k;
      logic                         hit;
      iv   = step_q();
      ctr  = 16'(centre_of(cursor));
      pick = peak_frame;
      k    = bgps_pkg::KIND_PEAK;
      hit  = 1'b0;
      b    = NO_BEAT;
      if (peak_level < cfg_floor) begin
         pick = ctr;
         k    = bgps_pkg::KIND_CENTER;
      end else if (peak_frame > last_beat_frame &&
                   (32'(peak_frame - last_beat_frame) << (FRAC + 1)) < 32'(iv)) begin
         // Too close to the previous beat: fall back to the grid centre.
         pick = ctr;
         k    = bgps_pkg::KIND_CENTER;
      end
      if (pick > last_beat_frame) begin
         b               = '{pick, k};
         last_beat_frame = pick;
         hit             = 1'b1;
      end
      cursor_load(cursor + 26'(iv));
      return hit;
   endfunction

   // Advance the predicted state by one sample and report the beat it causes, if any.
   function automatic logic predict_beat(input logic signed [bgps_pkg::LEVEL_W-1:0] level,
                                         input logic last, output beat_type b);
      logic [16:0] idx;
      logic [17:0] c;
      logic [17:0] w;
      logic [17:0] lo;
      logic [17:0] hi;
      logic [16:0] fin;
      logic        got;
      idx = frame_idx;
      got = 1'b0;
      b   = NO_BEAT;
      if (idx < FRAME_LIMIT) begin
         if (!anchor_done && idx == cfg_start) begin
            b               = '{cfg_start, bgps_pkg::KIND_ANCHOR};
            got             = 1'b1;
            anchor_done     = 1'b1;
            last_beat_frame = cfg_start;
            if (cfg_end <= cfg_start) begin
               win_open = 1'b0;
            end else begin
               cursor_load({2'b00, cfg_start, 8'h00} + 26'(step_q()));
            end
         end else if (win_open) begin
            c  = centre_of(cursor);
            w  = 18'((step_q() + 25'd512) >> (FRAC + 2));
            if (w < 18'd1) begin
               w = 18'd1;
            end
            lo = (c > w) ? c - w : 18'd0;
            hi = c + w;
            if (hi > FRAME_LIMIT - 1) begin
               hi = 18'(FRAME_LIMIT - 1);
            end
            if (idx >= lo && idx <= hi && level > peak_level) begin
               peak_level = level;
               peak_frame = 16'(idx);
            end
            if (idx >= hi) begin
               got = window_close(b);
            end
         end
         frame_idx = idx + 17'd1;
      end
      // The final sample cuts a pending window and clears the run.
      if (last) begin
         fin = (idx < FRAME_LIMIT) ? idx : 17'(FRAME_LIMIT - 1);
         if (!got && win_open && cursor <= {1'b0, fin, 8'h00}) begin
            got = window_close(b);
         end
         run_clear();
      end
      return got;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Prediction on accepted samples and checking of accepted beats
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      beat_type next_beat;
      beat_type due;
      logic     got;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            got = predict_beat(req_bus.activation_level, req_bus.last_sample, next_beat);
            n_samples++;
            if (req_bus.last_sample) begin
               n_runs++;
            end
            case (row_check)
               EXP_MODEL: begin
                  if (got) begin
                     beats_due.insert(beats_due.size(), next_beat);
                  end
               end
               EXP_BEAT: begin
                  beats_due.insert(beats_due.size(), row_beat);
               end
               default: begin
               end
            endcase
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (beats_due.size() == 0) begin
               note_failure($sformatf("beat with nothing expected: frame %0d kind %0d",
                                      rsp_bus.beat_frame, rsp_bus.beat_kind));
            end else begin
               due = beats_due.pop_front();
               if (rsp_bus.beat_frame !== due.frame || rsp_bus.beat_kind !== due.kind) begin
                  note_failure($sformatf({"beat mismatch: expected frame %0d kind %0d,",
                                          " got frame %0d kind %0d"},
                                         due.frame, due.kind, rsp_bus.beat_frame,
                                         rsp_bus.beat_kind));
               end else begin
                  kind_seen[due.kind]++;
               end
            end
         end
      end
      rsp_bus.ready <= !rsp_hold && ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Long hold-off of the receiver while the sender keeps offering samples.
   initial begin : long_hold
      int held;
      rsp_hold <= 1'b0;
      wait (stall_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      for (held = 0; held < HOLD_CYCLES; held++) begin
         @(posedge clock);
      end
      rsp_hold <= 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------------

   // Offer one sample transaction and return at the edge where it is accepted.
   task automatic send_sample(input logic [15:0] level, input logic last,
                              input check_type check, input beat_type typed);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid            <= 1'b1;
      req_bus.activation_level <= level;
      req_bus.last_sample      <= last;
      row_check                <= check;
      row_beat                 <= typed;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Stop sending and wait until every expected beat has been taken.
   task automatic settle();
      int waited;
      waited = 0;
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (beats_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (beats_due.size() != 0) begin
         note_failure($sformatf("%0d expected beats never arrived, first frame %0d kind %0d",
                                beats_due.size(), beats_due[0].frame, beats_due[0].kind));
         beats_due.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input bgps_pkg::csr_index_type idx, input logic [23:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         bgps_pkg::CSR_BEAT_INTERVAL:    cfg_interval = value;
         bgps_pkg::CSR_ACTIVATION_FLOOR: cfg_floor    = value[15:0];
         bgps_pkg::CSR_START_FRAME:      cfg_start    = value[15:0];
         bgps_pkg::CSR_END_FRAME:        cfg_end      = value[15:0];
         default: begin
         end
      endcase
      n_writes++;
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Write all four registers; the unused upper data bits carry noise.
   task automatic apply_setting(input logic [23:0] interval, input logic [15:0] floor_level,
                                input logic [15:0] start_at, input logic [15:0] end_at);
      settle();
      write_reg(bgps_pkg::CSR_BEAT_INTERVAL, interval);
      write_reg(bgps_pkg::CSR_ACTIVATION_FLOOR, {8'($urandom), floor_level});
      write_reg(bgps_pkg::CSR_START_FRAME, {8'($urandom), start_at});
      write_reg(bgps_pkg::CSR_END_FRAME, {8'($urandom), end_at});
      n_settings++;
   endtask

   // Activation levels: extremes, ties, values around the floor, and noise.
   function automatic logic [15:0] pick_level();
      case ($urandom_range(0, 7))
         0: return bgps_pkg::LEVEL_MIN;
         1: return 16'h7FFF;
         2, 3: return cfg_floor + 16'($urandom_range(0, 6)) - 16'd3;
         4: return 16'($urandom_range(0, 3));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic row_type smp(input logic [15:0] level, input logic last);
      return '{ROW_SAMPLE, bgps_pkg::CSR_BEAT_INTERVAL, {8'h00, level}, last, EXP_MODEL,
               16'h0000, bgps_pkg::KIND_ANCHOR};
   endfunction

   function automatic row_type smp_none(input logic [15:0] level, input logic last);
      return '{ROW_SAMPLE, bgps_pkg::CSR_BEAT_INTERVAL, {8'h00, level}, last, EXP_NONE,
               16'h0000, bgps_pkg::KIND_ANCHOR};
   endfunction

   function automatic row_type smp_beat(input logic [15:0] level, input logic last,
                                        input logic [15:0] frame,
                                        input bgps_pkg::beat_kind_type kind);
      return '{ROW_SAMPLE, bgps_pkg::CSR_BEAT_INTERVAL, {8'h00, level}, last, EXP_BEAT,
               frame, kind};
   endfunction

   function automatic row_type wr(input bgps_pkg::csr_index_type idx,
                                  input logic [23:0] value);
      return '{ROW_WRITE, idx, value, 1'b0, EXP_NONE, 16'h0000, bgps_pkg::KIND_ANCHOR};
   endfunction

   // ---------------------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------------------
   initial begin : stimulus
      row_type     script[$];
      logic [23:0] iv;
      logic [15:0] fl;
      logic [15:0] st;
      logic [15:0] en;
      int          p;
      int          sent;
      int          run_len;
      int          k;

      req_bus.valid            <= 1'b0;
      req_bus.activation_level <= '0;
      req_bus.last_sample      <= 1'b0;
      csr_bus.valid            <= 1'b0;
      csr_bus.index            <= bgps_pkg::CSR_BEAT_INTERVAL;
      csr_bus.data             <= '0;
      row_check                <= EXP_MODEL;
      row_beat                 <= NO_BEAT;
      reset                    <= 1'b1;

      cfg_interval = bgps_pkg::BEAT_INTERVAL_RESET;
      cfg_floor    = bgps_pkg::ACTIVATION_FLOOR_RESET;
      cfg_start    = bgps_pkg::START_FRAME_RESET;
      cfg_end      = bgps_pkg::END_FRAME_RESET;
      run_clear();
      beats_due.delete();
      failures   = 0;
      n_samples  = 0;
      n_runs     = 0;
      n_writes   = 0;
      n_settings = 1;
      kind_seen  = '{0, 0, 0};
      stall_go   = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part: sender idles 29 in a hundred, receiver 60.
      send_idle_pct = 29;
      recv_idle_pct = 60;
      script = '{
         // An interval below four frames counts as four.
         wr(bgps_pkg::CSR_BEAT_INTERVAL, 24'd0),
         smp_beat(16'h7FFF, 1'b0, 16'd0, bgps_pkg::KIND_ANCHOR),
         smp(16'h0000, 1'b0), smp(16'hFFFF, 1'b0), smp(16'h8000, 1'b0),
         smp(16'h7FFF, 1'b0), smp(16'h0064, 1'b0),
         // Whole window at the minimum level: the centre is taken.
         smp(16'h0005, 1'b0), smp(16'h8000, 1'b0), smp(16'h8000, 1'b0),
         smp(16'h8000, 1'b0),
         // Run ends before the cursor of the open window: nothing.
         smp(16'h0007, 1'b0), smp_none(16'h0007, 1'b1),
         // End frame not after the start frame: only the anchor.
         wr(bgps_pkg::CSR_START_FRAME, 24'd3), wr(bgps_pkg::CSR_END_FRAME, 24'd2),
         smp_none(16'h1234, 1'b0), smp_none(16'h5678, 1'b0), smp_none(16'hABCD, 1'b0),
         smp_beat(16'h0001, 1'b0, 16'd3, bgps_pkg::KIND_ANCHOR), smp_none(16'h7FFF, 1'b1),
         // Run ends before the anchor frame.
         wr(bgps_pkg::CSR_START_FRAME, 24'hFFFF), wr(bgps_pkg::CSR_END_FRAME, 24'hFFFF),
         smp_none(16'h7FFF, 1'b1),
         // Highest floor; the run ends inside a window whose cursor has been reached.
         wr(bgps_pkg::CSR_START_FRAME, 24'd0), wr(bgps_pkg::CSR_END_FRAME, 24'hFFFF),
         wr(bgps_pkg::CSR_BEAT_INTERVAL, 24'd1536),
         wr(bgps_pkg::CSR_ACTIVATION_FLOOR, 24'h007FFF),
         smp_beat(16'h8000, 1'b0, 16'd0, bgps_pkg::KIND_ANCHOR),
         smp(16'h0100, 1'b0), smp(16'h0200, 1'b0), smp(16'h0300, 1'b0),
         smp(16'h4E20, 1'b0), smp(16'hFFFB, 1'b0), smp(16'h7FFF, 1'b1)
      };
      foreach (script[i]) begin
         if (script[i].op == ROW_WRITE) begin
            settle();
            write_reg(script[i].reg_idx, script[i].value);
         end else begin
            send_sample(script[i].value[15:0], script[i].last, script[i].check,
                        '{script[i].frame, script[i].kind});
         end
      end

      // Random runs under changing settings; a phase may end in the middle of a run.
      for (p = 0; p < NUM_PHASES; p++) begin
         if (p == 4) begin
            send_idle_pct = 60;
            recv_idle_pct = 29;
         end else if (p == 8) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (p % 6)
            0: begin
               iv = 24'd1024; fl = bgps_pkg::LEVEL_MIN; st = '0; en = 16'hFFFF;
            end
            1: begin
               iv = 24'hFFFFFF; fl = 16'h7FFF; st = 16'($urandom_range(0, 20)); en = 16'hFFFF;
            end
            2: begin
               iv = 24'($urandom_range(1024, 6400)); fl = 16'($urandom);
               st = 16'($urandom_range(0, 40)); en = 16'hFFFF;
            end
            3: begin
               iv = 24'($urandom); fl = 16'($urandom);
               st = 16'($urandom_range(0, 10)); en = 16'($urandom);
            end
            4: begin
               iv = 24'($urandom_range(1024, 3000)); fl = 16'($urandom_range(0, 64)) - 16'd32;
               st = 16'($urandom_range(0, 10)); en = st + 16'($urandom_range(0, 120));
            end
            default: begin
               iv = 24'($urandom_range(0, 1023)); fl = 16'($urandom);
               st = 16'($urandom_range(0, 10)); en = 16'hFFFF;
            end
         endcase
         if (p == 8) begin
            // Dense beats while the receiver holds off, so the block backs up.
            iv = 24'd1024; fl = bgps_pkg::LEVEL_MIN; st = '0; en = 16'hFFFF;
         end
         apply_setting(iv, fl, st, en);
         if (p == 8) begin
            stall_go = 1'b1;
         end
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            run_len = $urandom_range(1, 160);
            for (k = 0; k < run_len && sent < PHASE_ITEMS; k++) begin
               send_sample(pick_level(), k == run_len - 1, EXP_MODEL, NO_BEAT);
               sent++;
            end
         end
      end
      settle();

      $display("Covered %0d samples in %0d finished runs under %0d settings,",
               n_samples, n_runs, n_settings);
      $display("%0d register writes; beats matched: %0d anchor, %0d peak, %0d centre.",
               n_writes, kind_seen[0], kind_seen[1], kind_seen[2]);
      if (failures == 0) begin
         $display("beat_grid_peak_snapper regression: pass");
      end else begin
         $display("beat_grid_peak_snapper regression: fail");
      end
      $finish;
   end

endmodule
